@@ rtl/serial_line_editor_macros.svh @@
// assertion macros shared by the serial line editor checkers
`ifndef SERIAL_LINE_EDITOR_MACROS_SVH
`define SERIAL_LINE_EDITOR_MACROS_SVH

// property checked on every rising edge outside reset
`define SLE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// a stalled signal keeps its value into the next cycle
`define SLE_HOLD(lbl, vld, rdy, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		(vld && !rdy) |=> (vld && $stable(sig))) else $error(msg);

`endif

@@ rtl/sle_pkg.sv @@
// constants, codes and ring index helpers for the serial line editor
`default_nettype none

package sle_pkg;

	// ring store geometry
	localparam int BUF_SLOTS = 128;
	localparam int IDX_W     = $clog2(BUF_SLOTS);

	// erase count width and saturation point
	localparam int CNT_W   = 7;
	localparam int SAT_W   = IDX_W + CNT_W;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// port widths
	localparam int CHAR_W      = 8;
	localparam int STATUS_W    = 3;
	localparam int OUT_TDATA_W = 24;

	// request kinds
	localparam logic REQ_CHAR = 1'b0;
	localparam logic REQ_READ = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_ECHO   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BELL   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ERASED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DONE   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_READ   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd5;
	localparam logic [STATUS_W-1:0] ST_BUSY   = 3'd6;

	// control characters
	localparam logic [CHAR_W-1:0] CH_BS     = 8'h08;
	localparam logic [CHAR_W-1:0] CH_DEL    = 8'h7F;
	localparam logic [CHAR_W-1:0] CH_CTRL_W = 8'h17;
	localparam logic [CHAR_W-1:0] CH_CTRL_U = 8'h15;
	localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;

	// ring successor
	function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] n);
		return (n == IDX_W'(BUF_SLOTS - 1)) ? '0 : n + IDX_W'(1);
	endfunction

	// ring predecessor
	function automatic logic [IDX_W-1:0] prev_slot(input logic [IDX_W-1:0] n);
		return (n == '0) ? IDX_W'(BUF_SLOTS - 1) : n - IDX_W'(1);
	endfunction

	// stored length, tail minus head modulo the ring size
	function automatic logic [IDX_W-1:0] ring_len(input logic [IDX_W-1:0] head,
			input logic [IDX_W-1:0] tail);
		logic [IDX_W:0] diff;
		diff = {1'b0, tail} - {1'b0, head};
		if (tail < head) begin
			diff = diff + (IDX_W + 1)'(BUF_SLOTS);
		end
		return diff[IDX_W-1:0];
	endfunction

	// length clipped to the erase count range
	function automatic logic [CNT_W-1:0] sat_count(input logic [IDX_W-1:0] len);
		return (SAT_W'(len) > SAT_W'(CNT_MAX)) ? CNT_MAX : CNT_W'(len);
	endfunction

	// space, tab, lf, vt, ff or cr
	function automatic logic is_blank(input logic [CHAR_W-1:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage

`default_nettype wire

@@ rtl/serial_line_editor.sv @@
// Serial line editor: ring-buffered line editing with echo, erase and line read-out.
// A character is decoded on accept and its result goes through S_OUT to the output register; a read passes S_READ
// for its one memory read first, and Ctrl-W walks back through S_WSCAN until the line empties or a blank stops it.
// One item at a time: s_tready is high only in S_IDLE; the word-erase scan reads one stored byte a cycle.
// Reset clears head, tail and the pending-line flag; the line store itself is not cleared.
`default_nettype none

module serial_line_editor (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [sle_pkg::CHAR_W-1:0]         s_tdata,  // rx_char[7:0]
	input  wire logic                               s_tuser,  // req_type[0]
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [sle_pkg::OUT_TDATA_W-1:0]         m_tdata,  // echo_char[7:0], erase_count[14:8], read_char[22:15], zero[23]
	output logic [sle_pkg::STATUS_W-1:0]            m_tuser,  // status[2:0]
	output logic                                    m_tlast   // read_last
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_READ  = 2'd1;
	localparam logic [1:0] S_WSCAN = 2'd2;
	localparam logic [1:0] S_OUT   = 2'd3;

	logic [1:0]                   state_q, state_d;
	logic [sle_pkg::IDX_W-1:0]    head_q, head_d, tail_q, tail_d;
	logic                         pending_q, pending_d;

	logic [sle_pkg::STATUS_W-1:0] res_status_q, res_status_d;
	logic [sle_pkg::CHAR_W-1:0]   res_echo_q, res_echo_d;
	logic [sle_pkg::CNT_W-1:0]    res_cnt_q, res_cnt_d;
	logic [sle_pkg::CHAR_W-1:0]   res_rd_q, res_rd_d;
	logic                         res_last_q, res_last_d;

	logic                         out_valid_q;
	logic [sle_pkg::STATUS_W-1:0] out_status_q;
	logic [sle_pkg::CHAR_W-1:0]   out_echo_q;
	logic [sle_pkg::CNT_W-1:0]    out_cnt_q;
	logic [sle_pkg::CHAR_W-1:0]   out_rd_q;
	logic                         out_last_q;

	logic [sle_pkg::CHAR_W-1:0]   line_mem [sle_pkg::BUF_SLOTS];
	logic                         mem_we, mem_re;
	logic [sle_pkg::IDX_W-1:0]    mem_wa, mem_ra;
	logic [sle_pkg::CHAR_W-1:0]   mem_wd, mem_rdata_q;

	logic                         accept, load_out;
	logic [sle_pkg::IDX_W-1:0]    len, prev_tail;

	// handshake and derived indices
	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign load_out  = (state_q == S_OUT) && (!out_valid_q || m_tready);
	assign len       = sle_pkg::ring_len(head_q, tail_q);
	assign prev_tail = sle_pkg::prev_slot(tail_q);

	// sequencer: decode on accept, memory read wait, word-erase scan, hand-off
	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		tail_d       = tail_q;
		pending_d    = pending_q;
		res_status_d = res_status_q;
		res_echo_d   = res_echo_q;
		res_cnt_d    = res_cnt_q;
		res_rd_d     = res_rd_q;
		res_last_d   = res_last_q;
		mem_we       = 1'b0;
		mem_wa       = tail_q;
		mem_wd       = s_tdata;
		mem_re       = 1'b0;
		mem_ra       = head_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_echo_d = '0;
					res_cnt_d  = '0;
					res_rd_d   = '0;
					res_last_d = 1'b0;
					state_d    = S_OUT;
					if (s_tuser == sle_pkg::REQ_READ) begin
						if (!pending_q || len == '0) begin
							res_status_d = sle_pkg::ST_EMPTY;
						end else begin
							mem_re  = 1'b1;
							mem_ra  = head_q;
							state_d = S_READ;
						end
					end else if (pending_q) begin
						res_status_d = sle_pkg::ST_BUSY;
					end else begin
						case (s_tdata) inside
							sle_pkg::CH_CR: begin
								mem_we       = 1'b1;
								mem_wd       = sle_pkg::CH_LF;
								tail_d       = sle_pkg::next_slot(tail_q);
								pending_d    = 1'b1;
								res_status_d = sle_pkg::ST_DONE;
							end
							sle_pkg::CH_BS, sle_pkg::CH_DEL: begin
								if (len == '0) begin
									res_status_d = sle_pkg::ST_BELL;
								end else begin
									tail_d       = prev_tail;
									res_cnt_d    = sle_pkg::CNT_W'(1);
									res_status_d = sle_pkg::ST_ERASED;
								end
							end
							sle_pkg::CH_CTRL_W: begin
								res_status_d = sle_pkg::ST_ERASED;
								if (len != '0) begin
									mem_re  = 1'b1;
									mem_ra  = prev_tail;
									state_d = S_WSCAN;
								end
							end
							sle_pkg::CH_CTRL_U: begin
								tail_d       = head_q;
								res_cnt_d    = sle_pkg::sat_count(len);
								res_status_d = sle_pkg::ST_ERASED;
							end
							default: begin
								if (len >= sle_pkg::IDX_W'(sle_pkg::BUF_SLOTS - 2)) begin
									res_status_d = sle_pkg::ST_BELL;
								end else begin
									mem_we       = 1'b1;
									mem_wd       = s_tdata;
									tail_d       = sle_pkg::next_slot(tail_q);
									res_echo_d   = s_tdata;
									res_status_d = sle_pkg::ST_ECHO;
								end
							end
						endcase
					end
				end
			end
			S_READ: begin
				res_status_d = sle_pkg::ST_READ;
				res_rd_d     = mem_rdata_q;
				head_d       = sle_pkg::next_slot(head_q);
				if (sle_pkg::next_slot(head_q) == tail_q) begin
					res_last_d = 1'b1;
					pending_d  = 1'b0;
				end
				state_d = S_OUT;
			end
			S_WSCAN: begin
				// read data is the byte just before the tail
				if (sle_pkg::is_blank(mem_rdata_q)) begin
					state_d = S_OUT;
				end else begin
					tail_d    = prev_tail;
					res_cnt_d = (res_cnt_q == sle_pkg::CNT_MAX) ? res_cnt_q
						: res_cnt_q + sle_pkg::CNT_W'(1);
					if (prev_tail == head_q) begin
						state_d = S_OUT;
					end else begin
						mem_re = 1'b1;
						mem_ra = sle_pkg::prev_slot(prev_tail);
					end
				end
			end
			S_OUT: begin
				if (load_out) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			pending_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			tail_q    <= tail_d;
			pending_q <= pending_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result under construction and output register
	always_ff @(posedge clk) begin
		res_status_q <= res_status_d;
		res_echo_q   <= res_echo_d;
		res_cnt_q    <= res_cnt_d;
		res_rd_q     <= res_rd_d;
		res_last_q   <= res_last_d;
		if (load_out) begin
			out_status_q <= res_status_q;
			out_echo_q   <= res_echo_q;
			out_cnt_q    <= res_cnt_q;
			out_rd_q     <= res_rd_q;
			out_last_q   <= res_last_q;
		end
	end

	// line store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			mem_rdata_q <= line_mem[mem_ra];
		end
	end

	// output packing
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_rd_q, out_cnt_q, out_echo_q};
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

@@ rtl/sle_checker.sv @@
// port-level checks for the serial line editor, bound to the top level
`default_nettype none

`include "serial_line_editor_macros.svh"

module sle_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               s_tvalid,
	input wire logic                               s_tready,
	input wire logic [sle_pkg::CHAR_W-1:0]         s_tdata,
	input wire logic                               s_tuser,
	input wire logic                               m_tvalid,
	input wire logic                               m_tready,
	input wire logic [sle_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input wire logic [sle_pkg::STATUS_W-1:0]       m_tuser,
	input wire logic                               m_tlast
);

	// a stalled result keeps its payload
	`SLE_HOLD(a_out_hold, m_tvalid, m_tready, {m_tdata, m_tuser, m_tlast}, "result changed while stalled")

	// one item at a time: no accept straight after an accept
	`SLE_ASSERT(a_one_at_a_time, (s_tvalid && s_tready) |=> !s_tready, "item accepted while busy")

	// read fields only on a read result
	`SLE_ASSERT(a_read_fields, (m_tvalid && m_tuser != sle_pkg::ST_READ) |-> (m_tdata[22:15] == 8'd0 && !m_tlast), "read fields set outside a read")

	// echo and erase fields only on their own statuses
	`SLE_ASSERT(a_edit_fields, m_tvalid |-> ((m_tuser == sle_pkg::ST_ECHO || m_tdata[7:0] == 8'd0) && (m_tuser == sle_pkg::ST_ERASED || m_tdata[14:8] == 7'd0) && !m_tdata[23]), "edit fields set outside their status")

endmodule

bind serial_line_editor sle_checker u_sle_checker (.*);

`default_nettype wire

@@ bench/serial_line_editor_checker.sv @@
// result checker for the serial line editor: mirrors the line store and compares every item
`timescale 1ns / 1ps

module serial_line_editor_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	input  logic                               s_tready,
	input  logic [sle_pkg::CHAR_W-1:0]         s_tdata,        // rx_char[7:0]
	input  logic                               s_tuser,        // req_type[0]
	input  logic                               m_tvalid,
	input  logic                               m_tready,
	input  logic [sle_pkg::OUT_TDATA_W-1:0]    m_tdata,        // echo_char[7:0], erase_count[14:8], read_char[22:15], zero[23]
	input  logic [sle_pkg::STATUS_W-1:0]       m_tuser,        // status[2:0]
	input  logic                               m_tlast,        // read_last
	output int                                 fail_count,
	output int                                 outstanding,
	output logic                               line_held,
	output int                                 results_seen,
	output int                                 lines_done,
	output int                                 bells_rung,
	output int                                 busy_refusals
);
	import sle_pkg::*;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [CHAR_W-1:0]   echo_char;
		logic [CNT_W-1:0]    erase_count;
		logic [CHAR_W-1:0]   read_char;
		logic                read_last;
	} editor_reply_t;

	// replies owed by the block, oldest first
	editor_reply_t awaited_replies[$];
	editor_reply_t due_reply;
	editor_reply_t fresh_reply;

	// own copy of the ring store and its pointers
	logic [CHAR_W-1:0] line_copy [BUF_SLOTS];
	int head_pos;
	int tail_pos;

	function automatic int stored_len();
		return (tail_pos + BUF_SLOTS - head_pos) % BUF_SLOTS;
	endfunction

	// work out the reply to one accepted item and update the mirrored line
	task automatic predict_reply(input logic req, input logic [CHAR_W-1:0] c,
			output editor_reply_t r);
		int erased;
		logic [CHAR_W-1:0] last_c;
		erased = 0;
		r.status = ST_ECHO;
		r.echo_char = '0;
		r.read_char = '0;
		r.read_last = 1'b0;
		if (req == REQ_READ) begin
			if (!line_held || stored_len() == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.status = ST_READ;
				r.read_char = line_copy[IDX_W'(head_pos)];
				head_pos = (head_pos + 1) % BUF_SLOTS;
				if (stored_len() == 0) begin
					r.read_last = 1'b1;
					line_held = 1'b0;
				end
			end
		end else if (line_held) begin
			r.status = ST_BUSY;
		end else if (c == CH_CR) begin
			line_copy[IDX_W'(tail_pos)] = CH_LF;
			tail_pos = (tail_pos + 1) % BUF_SLOTS;
			line_held = 1'b1;
			r.status = ST_DONE;
		end else if (c == CH_BS || c == CH_DEL) begin
			if (stored_len() == 0) begin
				r.status = ST_BELL;
			end else begin
				tail_pos = (tail_pos + BUF_SLOTS - 1) % BUF_SLOTS;
				erased = 1;
				r.status = ST_ERASED;
			end
		end else if (c == CH_CTRL_W) begin
			// walk back until the last stored byte is whitespace or the line is empty
			while (stored_len() > 0) begin
				last_c = line_copy[IDX_W'((tail_pos + BUF_SLOTS - 1) % BUF_SLOTS)];
				if (last_c == CH_SPACE || (last_c >= CH_TAB && last_c <= CH_CR)) begin
					break;
				end
				tail_pos = (tail_pos + BUF_SLOTS - 1) % BUF_SLOTS;
				erased++;
			end
			r.status = ST_ERASED;
		end else if (c == CH_CTRL_U) begin
			erased = stored_len();
			tail_pos = head_pos;
			r.status = ST_ERASED;
		end else if (stored_len() >= BUF_SLOTS - 2) begin
			// last slot kept for the newline
			r.status = ST_BELL;
		end else begin
			line_copy[IDX_W'(tail_pos)] = c;
			tail_pos = (tail_pos + 1) % BUF_SLOTS;
			r.echo_char = c;
		end
		r.erase_count = (erased > CNT_MAX) ? CNT_MAX : CNT_W'(erased);
	endtask

	task automatic compare_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
			fail_count++;
		end
	endtask

	// result side first, then the new item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaited_replies.delete();
			head_pos = 0;
			tail_pos = 0;
			line_held = 1'b0;
			fail_count = 0;
			outstanding = 0;
			results_seen = 0;
			lines_done = 0;
			bells_rung = 0;
			busy_refusals = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (awaited_replies.size() == 0) begin
					$display("%0t: unexpected item, status 0x%0h data 0x%0h last %0d",
						$time, m_tuser, m_tdata, m_tlast);
					fail_count++;
				end else begin
					due_reply = awaited_replies.pop_front();
					compare_field("status", int'(due_reply.status), int'(m_tuser));
					compare_field("echo_char", int'(due_reply.echo_char),
						int'(m_tdata[7:0]));
					compare_field("erase_count", int'(due_reply.erase_count),
						int'(m_tdata[14:8]));
					compare_field("read_char", int'(due_reply.read_char),
						int'(m_tdata[22:15]));
					compare_field("tdata pad bit", 0, int'(m_tdata[23]));
					compare_field("read_last", int'(due_reply.read_last), int'(m_tlast));
				end
			end
			if (s_tvalid && s_tready) begin
				predict_reply(s_tuser, s_tdata, fresh_reply);
				awaited_replies.push_back(fresh_reply);
				if (fresh_reply.status == ST_DONE) lines_done++;
				if (fresh_reply.status == ST_BELL) bells_rung++;
				if (fresh_reply.status == ST_BUSY) busy_refusals++;
			end
			outstanding = awaited_replies.size();
		end
	end

endmodule

@@ bench/serial_line_editor_test.sv @@
// testbench top for the serial line editor: clock, reset, typed lines and the verdict
`timescale 1ns / 1ps

module serial_line_editor_test;
	import sle_pkg::*;

	localparam int ITEM_GOAL   = 1750;
	localparam int CYCLE_LIMIT = 1_500_000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [CHAR_W-1:0]      s_tdata = '0;      // rx_char[7:0]
	logic                   s_tuser = REQ_CHAR; // req_type[0]
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;           // echo_char[7:0], erase_count[14:8], read_char[22:15], zero[23]
	logic [STATUS_W-1:0]    m_tuser;           // status[2:0]
	logic                   m_tlast;           // read_last

	int fail_count;
	int outstanding;
	logic line_held;
	int results_seen;
	int lines_done;
	int bells_rung;
	int busy_refusals;

	int items_sent = 0;
	int cycle_count = 0;
	int tx_calm = 0;
	int rx_calm = 0;
	int rx_stall;

	serial_line_editor i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	serial_line_editor_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.line_held     (line_held),
		.results_seen  (results_seen),
		.lines_done    (lines_done),
		.bells_rung    (bells_rung),
		.busy_refusals (busy_refusals)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("serial_line_editor regression: fail");
			$finish;
		end
	end

	// wait before the next item, with occasional stretches of none
	function automatic int draw_wait(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			calm_left = $urandom_range(16, 64);
			return 0;
		end
		return $urandom_range(0, 16);
	endfunction

	// random byte
	function automatic logic [CHAR_W-1:0] any_char();
		return CHAR_W'($urandom_range(0, 255));
	endfunction

	// result side: random stalls per item
	initial begin
		forever begin
			rx_stall = draw_wait(rx_calm);
			repeat (rx_stall) begin
				@(negedge clk);
				m_tready <= 1'b0;
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(input logic req, input logic [CHAR_W-1:0] ch);
		int gap;
		gap = draw_wait(tx_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= ch;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		@(negedge clk);
	endtask

	// idle the sender until every owed result has come back
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	// any byte that is not an editing key
	function automatic logic [CHAR_W-1:0] plain_char();
		logic [CHAR_W-1:0] c;
		do c = CHAR_W'($urandom_range(0, 255));
		while (c == CH_CR || c == CH_BS || c == CH_DEL || c == CH_CTRL_W || c == CH_CTRL_U);
		return c;
	endfunction

	// space, tab, lf, vt or ff
	function automatic logic [CHAR_W-1:0] blank_char();
		if ($urandom_range(0, 1) == 0) return CH_SPACE;
		return CH_TAB + CHAR_W'($urandom_range(0, 3));
	endfunction

	// type one line with edits, complete it and read it back out
	task automatic type_line(input bit force_long);
		int target;
		int pick;
		bit wordy;
		if (force_long || $urandom_range(0, 9) == 0) begin
			// long line of 118 to 140 characters, may run into the full store
			target = $urandom_range(118, 140);
			wordy = ($urandom_range(0, 2) != 0);
			repeat (target) begin
				if (wordy && $urandom_range(0, 15) == 0) send_item(REQ_CHAR, blank_char());
				else send_item(REQ_CHAR, plain_char());
			end
			case ($urandom_range(0, 3))
				0: send_item(REQ_CHAR, CH_CTRL_U);
				1: send_item(REQ_CHAR, CH_CTRL_W);
				default: ;
			endcase
		end else begin
			target = $urandom_range(0, 18);
			repeat (target) begin
				pick = $urandom_range(0, 99);
				if (pick < 60) send_item(REQ_CHAR, plain_char());
				else if (pick < 72) send_item(REQ_CHAR, blank_char());
				else if (pick < 77) send_item(REQ_CHAR, CH_BS);
				else if (pick < 82) send_item(REQ_CHAR, CH_DEL);
				else if (pick < 88) send_item(REQ_CHAR, CH_CTRL_W);
				else if (pick < 91) send_item(REQ_CHAR, CH_CTRL_U);
				else if (pick < 94) send_item(REQ_READ, any_char());
				else send_item(1'($urandom_range(0, 1)), any_char());
			end
		end
		if ($urandom_range(0, 19) != 0) send_item(REQ_CHAR, CH_CR);
		// drain, with some characters refused on the way
		while (line_held) begin
			if ($urandom_range(0, 6) == 0) send_item(REQ_CHAR, any_char());
			else send_item(REQ_READ, any_char());
		end
		repeat ($urandom_range(0, 2)) send_item(REQ_READ, any_char());
	endtask

	// stimulus and verdict
	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// empty line: read, erasers and the bell
		send_item(REQ_READ, 8'hFF);
		send_item(REQ_CHAR, CH_BS);
		send_item(REQ_CHAR, CH_DEL);
		send_item(REQ_CHAR, CH_CTRL_W);
		send_item(REQ_CHAR, CH_CTRL_U);
		// extremes, a word erase, a read before the line is complete and single erases
		send_item(REQ_CHAR, 8'h00);
		send_item(REQ_CHAR, 8'hFF);
		send_item(REQ_CHAR, 8'h41);
		send_item(REQ_CHAR, CH_TAB);
		send_item(REQ_CHAR, 8'h62);
		send_item(REQ_CHAR, 8'h63);
		send_item(REQ_CHAR, CH_CTRL_W);
		send_item(REQ_READ, 8'h00);
		send_item(REQ_CHAR, CH_DEL);
		send_item(REQ_CHAR, CH_BS);
		send_item(REQ_CHAR, 8'h7E);
		send_item(REQ_CHAR, CH_CTRL_U);
		// completed line, busy refusal, read-out to the last byte and past it
		send_item(REQ_CHAR, 8'h80);
		send_item(REQ_CHAR, CH_CR);
		send_item(REQ_CHAR, 8'h55);
		send_item(REQ_READ, 8'h00);
		send_item(REQ_READ, 8'hAA);
		send_item(REQ_READ, 8'h00);
		// line holding only the newline
		send_item(REQ_CHAR, CH_CR);
		send_item(REQ_READ, 8'h00);
		settle();

		// random lines, the first one long enough that it may fill the store
		type_line(1'b1);
		while (items_sent < ITEM_GOAL) begin
			type_line(1'b0);
			if ($urandom_range(0, 7) == 0) settle();
		end

		// drain and let the block go quiet
		settle();
		repeat (BUF_SLOTS + 8) @(negedge clk);

		$display("%0d items sent, %0d results checked, %0d lines completed and read out",
			items_sent, results_seen, lines_done);
		$display("%0d bells on empty or full lines, %0d characters refused while a line waited",
			bells_rung, busy_refusals);
		if (fail_count == 0) begin
			$display("serial_line_editor regression: pass");
		end else begin
			$display("serial_line_editor regression: fail");
		end
		$finish;
	end

endmodule
